FILE: design/clx_pkg.sv
// Shared types, constants and helper functions for the C-subset lexer.
// Used by the scanner front end, the token queue, the output stage and the top level.
// No dependencies.
package clx_pkg;

  // Longest lexeme position that can still match a keyword
  localparam int MAX_LEX = 32;

  // Token queue geometry
  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;

  // Token kinds
  localparam logic [5:0] K_END    = 6'd0;
  localparam logic [5:0] K_IDENT  = 6'd1;
  localparam logic [5:0] K_INT    = 6'd2;
  localparam logic [5:0] K_CHAR   = 6'd3;
  localparam logic [5:0] K_KW0    = 6'd4;
  localparam logic [5:0] K_PLUS   = 6'd12;
  localparam logic [5:0] K_MINUS  = 6'd13;
  localparam logic [5:0] K_STAR   = 6'd14;
  localparam logic [5:0] K_SLASH  = 6'd15;
  localparam logic [5:0] K_PCT    = 6'd16;
  localparam logic [5:0] K_COMMA  = 6'd17;
  localparam logic [5:0] K_SEMI   = 6'd18;
  localparam logic [5:0] K_LBRACE = 6'd19;
  localparam logic [5:0] K_RBRACE = 6'd20;
  localparam logic [5:0] K_LPAREN = 6'd21;
  localparam logic [5:0] K_RPAREN = 6'd22;
  localparam logic [5:0] K_LT     = 6'd23;
  localparam logic [5:0] K_LE     = 6'd24;
  localparam logic [5:0] K_SHL    = 6'd25;
  localparam logic [5:0] K_GT     = 6'd26;
  localparam logic [5:0] K_GE     = 6'd27;
  localparam logic [5:0] K_SHR    = 6'd28;
  localparam logic [5:0] K_ASSIGN = 6'd29;
  localparam logic [5:0] K_EQEQ   = 6'd30;
  localparam logic [5:0] K_NE     = 6'd31;
  localparam logic [5:0] K_ERR    = 6'd32;

  // Error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_EMPTY   = 3'd1;
  localparam logic [2:0] E_ESCQ    = 3'd2;
  localparam logic [2:0] E_LONG    = 3'd3;
  localparam logic [2:0] E_BANG    = 3'd4;
  localparam logic [2:0] E_UNKNOWN = 3'd5;

  // Source bytes of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BLANK2 = 8'hCD;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    M_IDLE,
    M_COMMENT,
    M_SLASH,
    M_INT,
    M_IDENT,
    M_LT,
    M_GT,
    M_EQ,
    M_BANG,
    M_Q1,
    M_QESC,
    M_QBODY
  } scan_mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [7:0]  len;
    logic [2:0]  err;
    logic        last;
  } token_t;

  // Tokens produced by one byte; v1 is only set together with v0
  typedef struct packed {
    logic   v0;
    logic   v1;
    token_t t0;
    token_t t1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_PCT:    k = K_PCT;
      CH_COMMA:  k = K_COMMA;
      CH_SEMI:   k = K_SEMI;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      default:   k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] adv_line(input logic [15:0] l, input logic [7:0] c);
    return ((c == CH_NL) && (l != 16'hFFFF)) ? l + 16'd1 : l;
  endfunction

  function automatic logic [15:0] adv_col(input logic [15:0] col, input logic [7:0] c);
    logic [15:0] r;
    if (c == CH_NL) begin
      r = 16'd1;
    end else if (col != 16'hFFFF) begin
      r = col + 16'd1;
    end else begin
      r = col;
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [7:0] kw_len(input logic [2:0] k);
    logic [7:0] n;
    unique case (k)
      3'd0:    n = 8'd2;
      3'd1:    n = 8'd4;
      3'd2:    n = 8'd3;
      3'd3:    n = 8'd6;
      3'd4:    n = 8'd6;
      3'd5:    n = 8'd7;
      3'd6:    n = 8'd6;
      default: n = 8'd5;
    endcase
    return n;
  endfunction

  // Keyword text, first byte in the top byte
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [63:0] s;
    unique case (k)
      3'd0:    s = {"if", 48'h0};
      3'd1:    s = {"else", 32'h0};
      3'd2:    s = {"int", 40'h0};
      3'd3:    s = {"double", 16'h0};
      3'd4:    s = {"public", 16'h0};
      3'd5:    s = {"private", 8'h0};
      3'd6:    s = {"return", 16'h0};
      default: s = {"class", 24'h0};
    endcase
    return s[8 * (7 - int'(pos)) +: 8];
  endfunction

  // Drop keywords that cannot match once byte c sits at position len
  function automatic logic [7:0] kw_mask_upd(input logic [7:0] mask, input logic [7:0] len,
                                             input logic [7:0] c);
    logic [7:0] m;
    m = mask;
    for (int k = 0; k < 8; k++) begin
      if ((len >= kw_len(3'(k))) || (len >= 8'(MAX_LEX)) ||
          (kw_char(3'(k), len[2:0]) != c)) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [7:0] mask, input logic [7:0] len);
    logic [5:0] kind;
    logic       found;
    kind  = K_IDENT;
    found = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!found && mask[k] && (kw_len(3'(k)) == len)) begin
        kind  = K_KW0 + 6'(k);
        found = 1'b1;
      end
    end
    return kind;
  endfunction

endpackage

FILE: design/clx_front.sv
// Scanner front end of the C-subset lexer: takes one source byte per beat,
// steps the scan state machine and hands up to two tokens to the queue.
// Depends on clx_pkg.
module clx_front
  import clx_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     ch,
  input  logic [QAW:0]   q_level,
  output push_t          push
);

  scan_mode_t  mode, mode_next;
  logic [15:0] line_cnt, line_cnt_next;
  logic [15:0] col_cnt, col_cnt_next;
  logic [15:0] tok_line, tok_line_next;
  logic [15:0] tok_col, tok_col_next;
  logic [7:0]  tok_len, tok_len_next;
  logic [7:0]  kw_mask, kw_mask_next;
  logic        halted, halted_next;

  logic        accept;

  // Token held over from the previous byte
  logic        a_v;
  logic [5:0]  a_kind;
  logic [7:0]  a_len;
  logic [2:0]  a_err;
  logic        do_idle;

  // Outcome of scanning the byte from the idle state
  scan_mode_t  id_mode;
  logic [15:0] id_line, id_col, id_tline, id_tcol;
  logic [7:0]  id_tlen, id_mask;
  logic        id_halt, id_v;
  logic [5:0]  id_kind;
  logic [7:0]  id_len;
  logic [2:0]  id_err;

  // Two-byte operator choices for the current mode
  logic [5:0]  pr_single, pr_eq, pr_dup;
  logic [7:0]  pr_dupc;
  logic        pr_has_dup;

  logic [15:0] line_adv, col_adv;
  logic [7:0]  len_inc;

  // Take a byte only when the queue can hold two tokens
  assign in_ready = (q_level <= (QAW + 1)'(QDEPTH - 2));
  assign accept   = in_valid && in_ready;

  assign line_adv = adv_line(line_cnt, ch);
  assign col_adv  = adv_col(col_cnt, ch);
  assign len_inc  = sat_inc8(tok_len);

  // Pick the operator kinds that depend on the first byte
  always_comb begin
    pr_single  = K_ASSIGN;
    pr_eq      = K_EQEQ;
    pr_dup     = K_EQEQ;
    pr_dupc    = CH_NUL;
    pr_has_dup = 1'b0;
    unique case (mode)
      M_LT: begin
        pr_single  = K_LT;
        pr_eq      = K_LE;
        pr_dup     = K_SHL;
        pr_dupc    = CH_LT;
        pr_has_dup = 1'b1;
      end
      M_GT: begin
        pr_single  = K_GT;
        pr_eq      = K_GE;
        pr_dup     = K_SHR;
        pr_dupc    = CH_GT;
        pr_has_dup = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Scan the byte as the first byte after a token boundary
  always_comb begin
    id_mode  = M_IDLE;
    id_line  = line_cnt;
    id_col   = col_cnt;
    id_tline = tok_line;
    id_tcol  = tok_col;
    id_tlen  = tok_len;
    id_mask  = kw_mask;
    id_halt  = 1'b0;
    id_v     = 1'b0;
    id_kind  = K_END;
    id_len   = 8'd0;
    id_err   = E_NONE;
    priority if (ch == CH_NUL) begin
      id_tline = line_cnt;
      id_tcol  = col_cnt;
      id_tlen  = 8'd0;
      id_v     = 1'b1;
    end else if ((ch == CH_SP) || (ch == CH_NL) || (ch == CH_TAB) || (ch == CH_BLANK2)) begin
      id_line = line_adv;
      id_col  = col_adv;
    end else begin
      id_tline = line_cnt;
      id_tcol  = col_cnt;
      id_tlen  = 8'd1;
      id_line  = line_adv;
      id_col   = col_adv;
      priority if (is_digit(ch)) begin
        id_mode = M_INT;
      end else if (is_letter(ch)) begin
        id_mask = kw_mask_upd(8'hFF, 8'd0, ch);
        id_mode = M_IDENT;
      end else if (single_kind(ch) != K_END) begin
        id_v    = 1'b1;
        id_kind = single_kind(ch);
        id_len  = 8'd1;
      end else begin
        unique case (ch)
          CH_SLASH: id_mode = M_SLASH;
          CH_QUOTE: id_mode = M_Q1;
          CH_LT:    id_mode = M_LT;
          CH_GT:    id_mode = M_GT;
          CH_EQ:    id_mode = M_EQ;
          CH_BANG:  id_mode = M_BANG;
          default: begin
            // Unknown byte: not consumed, zero-length error
            id_tlen = 8'd0;
            id_line = line_cnt;
            id_col  = col_cnt;
            id_v    = 1'b1;
            id_kind = K_ERR;
            id_err  = E_UNKNOWN;
            id_halt = 1'b1;
          end
        endcase
      end
    end
  end

  // Next state: finish or extend the pending token, then rescan if needed
  always_comb begin
    mode_next     = mode;
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_len_next  = tok_len;
    kw_mask_next  = kw_mask;
    halted_next   = halted;
    a_v           = 1'b0;
    a_kind        = K_END;
    a_len         = tok_len;
    a_err         = E_NONE;
    do_idle       = 1'b0;
    unique case (mode)
      M_COMMENT: begin
        if ((ch == CH_NL) || (ch == CH_NUL)) begin
          do_idle = 1'b1;
        end else begin
          line_cnt_next = line_adv;
          col_cnt_next  = col_adv;
        end
      end
      M_SLASH: begin
        if (ch == CH_SLASH) begin
          line_cnt_next = line_adv;
          col_cnt_next  = col_adv;
          mode_next     = M_COMMENT;
        end else begin
          a_v     = 1'b1;
          a_kind  = K_SLASH;
          do_idle = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit(ch)) begin
          tok_len_next  = len_inc;
          line_cnt_next = line_adv;
          col_cnt_next  = col_adv;
        end else begin
          a_v     = 1'b1;
          a_kind  = K_INT;
          do_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_digit(ch) || is_letter(ch)) begin
          kw_mask_next  = kw_mask_upd(kw_mask, tok_len, ch);
          tok_len_next  = len_inc;
          line_cnt_next = line_adv;
          col_cnt_next  = col_adv;
        end else begin
          a_v     = 1'b1;
          a_kind  = ident_kind(kw_mask, tok_len);
          do_idle = 1'b1;
        end
      end
      M_LT, M_GT, M_EQ: begin
        if ((ch == CH_EQ) || (pr_has_dup && (ch == pr_dupc))) begin
          tok_len_next  = len_inc;
          line_cnt_next = line_adv;
          col_cnt_next  = col_adv;
          a_v           = 1'b1;
          a_kind        = (ch == CH_EQ) ? pr_eq : pr_dup;
          a_len         = len_inc;
          mode_next     = M_IDLE;
        end else begin
          a_v     = 1'b1;
          a_kind  = pr_single;
          do_idle = 1'b1;
        end
      end
      M_BANG: begin
        a_v       = 1'b1;
        mode_next = M_IDLE;
        if (ch == CH_EQ) begin
          tok_len_next  = len_inc;
          line_cnt_next = line_adv;
          col_cnt_next  = col_adv;
          a_kind        = K_NE;
          a_len         = len_inc;
        end else begin
          a_kind      = K_ERR;
          a_err       = E_BANG;
          halted_next = 1'b1;
        end
      end
      M_Q1, M_QESC: begin
        if (ch == CH_NUL) begin
          a_v         = 1'b1;
          a_kind      = K_ERR;
          a_err       = E_LONG;
          halted_next = 1'b1;
          mode_next   = M_IDLE;
        end else begin
          tok_len_next  = len_inc;
          line_cnt_next = line_adv;
          col_cnt_next  = col_adv;
          if (ch == CH_QUOTE) begin
            a_v         = 1'b1;
            a_kind      = K_ERR;
            a_len       = len_inc;
            a_err       = (mode == M_Q1) ? E_EMPTY : E_ESCQ;
            halted_next = 1'b1;
            mode_next   = M_IDLE;
          end else if ((mode == M_Q1) && (ch == CH_BSLASH)) begin
            mode_next = M_QESC;
          end else begin
            mode_next = M_QBODY;
          end
        end
      end
      M_QBODY: begin
        a_v       = 1'b1;
        mode_next = M_IDLE;
        if (ch == CH_NUL) begin
          a_kind      = K_ERR;
          a_err       = E_LONG;
          halted_next = 1'b1;
        end else begin
          tok_len_next  = len_inc;
          line_cnt_next = line_adv;
          col_cnt_next  = col_adv;
          a_len         = len_inc;
          if (ch == CH_QUOTE) begin
            a_kind = K_CHAR;
          end else begin
            a_kind      = K_ERR;
            a_err       = E_LONG;
            halted_next = 1'b1;
          end
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase
    if (do_idle) begin
      mode_next     = id_mode;
      line_cnt_next = id_line;
      col_cnt_next  = id_col;
      tok_line_next = id_tline;
      tok_col_next  = id_tcol;
      tok_len_next  = id_tlen;
      kw_mask_next  = id_mask;
      halted_next   = id_halt;
    end
  end

  // Pack the held-over token first, the rescan token second
  always_comb begin
    token_t ta, tb;
    logic   b_v;
    ta   = '{kind: a_kind, line: tok_line, col: tok_col, len: a_len, err: a_err,
             last: 1'b1};
    tb   = '{kind: id_kind, line: id_tline, col: id_tcol, len: id_len, err: id_err,
             last: 1'b1};
    b_v  = do_idle && id_v;
    push = '0;
    if (accept && !halted) begin
      push.v0      = a_v || b_v;
      push.v1      = a_v && b_v;
      push.t0      = a_v ? ta : tb;
      push.t0.last = !(a_v && b_v);
      push.t1      = tb;
    end
  end

  // Hold state while halted or idle on the input
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      line_cnt <= 16'd1;
      col_cnt  <= 16'd1;
      tok_line <= 16'd1;
      tok_col  <= 16'd1;
      tok_len  <= 8'd0;
      kw_mask  <= 8'hFF;
      halted   <= 1'b0;
    end else if (accept && !halted) begin
      mode     <= mode_next;
      line_cnt <= line_cnt_next;
      col_cnt  <= col_cnt_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_len  <= tok_len_next;
      kw_mask  <= kw_mask_next;
      halted   <= halted_next;
    end
  end

endmodule

FILE: design/clx_queue.sv
// Token queue between the scanner front end and the output stage.
// Takes up to two tokens per cycle, gives one per cycle when the output stage pops. Depends on clx_pkg.
module clx_queue
  import clx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  input  logic         pop,
  output token_t       head,
  output logic [QAW:0] level
);

  token_t         entries [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW-1:0] wptr1;

  assign wptr1 = wptr + QAW'(1);
  assign head  = entries[rptr];

  // Store payload
  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wptr] <= push.t0;
    end
    if (push.v1) begin
      entries[wptr1] <= push.t1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + QAW'(push.v0) + QAW'(push.v1);
      rptr  <= rptr + QAW'(pop);
      level <= level + (QAW + 1)'(push.v0) + (QAW + 1)'(push.v1) - (QAW + 1)'(pop);
    end
  end

endmodule

FILE: design/clx_back.sv
// Output stage of the C-subset lexer: moves tokens from the queue into a
// registered master-side beat. Depends on clx_pkg.
module clx_back
  import clx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [QAW:0] q_level,
  input  token_t       q_head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output token_t       out_tok
);

  // Load a new token whenever the output register is free or being drained
  assign pop = (q_level != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= (q_level != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_tok <= q_head;
    end
  end

endmodule

FILE: design/c_subset_lexer_unit.sv
// Top level of the C-subset lexer: byte stream in, token stream out.
// Depends on clx_pkg, clx_front, clx_queue and clx_back.

// The lexer takes one source byte per beat and returns tokens, each with kind,
// start line, start column, length and error code; tlast marks the final token
// caused by a byte. Each byte is scanned combinationally, and a token passes
// through the token queue and the output register. Bytes stream in at one per
// cycle as long as the four-entry token queue has room for two tokens; the master
// side moves one token per beat, so a byte that ends one token and starts another
// costs two output beats and text that yields more tokens than bytes is paced by
// the output port. After an error token the lexer drops every byte until reset.
module c_subset_lexer_unit
  import clx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] start_line, [31:16] start_column,
                                 // [39:32] token_length, [42:40] error_code
  output logic [5:0]  m_tuser,   // [5:0] token_kind
  output logic        m_tlast
);

  push_t        push;
  logic         pop;
  token_t       q_head;
  logic [QAW:0] q_level;
  token_t       out_tok;

  clx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .ch       (s_tdata),
    .q_level  (q_level),
    .push     (push)
  );

  clx_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (q_head),
    .level (q_level)
  );

  clx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_level   (q_level),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (out_tok)
  );

  // Unpack the output token onto the stream fields
  assign m_tdata = {5'b0, out_tok.err, out_tok.len, out_tok.col, out_tok.line};
  assign m_tuser = out_tok.kind;
  assign m_tlast = out_tok.last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= (QAW + 1)'(QDEPTH))
    else $error("token queue over its depth");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (q_level <= (QAW + 1)'(QDEPTH - 2)))
    else $error("byte accepted without room for two tokens");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == K_ERR)) |-> m_tlast)
    else $error("error token not last of its byte");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == K_ERR) == (m_tdata[42:40] != E_NONE)))
    else $error("error code does not match token kind");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for c_subset_lexer_unit: feeds source bytes and checks every token.
// Holds its own scanner model; depends on clx_pkg and the lexer RTL only.
module tb;
  import clx_pkg::*;

  localparam int MAIN_BYTES = 420;
  localparam int PHASE_A    = 320;
  localparam int PHASE_B    = 640;

  typedef struct {
    logic [7:0] ch;
    bit         drain;
  } text_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [5:0]  m_tuser;
  logic        m_tlast;
  logic        rx_hold = 1'b0;

  text_byte_t  source_text[$];
  token_t      tokens_due[$];
  bit          drain_next;
  int          bytes_in;
  int          fails;

  string kw_words[8] = '{"if", "else", "int", "double", "public", "private", "return", "class"};
  string op_words[20] = '{"+", "-", "*", "/", "%", ",", ";", "{", "}", "(", ")",
                          "<", "<=", "<<", ">", ">=", ">>", "=", "==", "!="};

  // Scanner model state
  scan_mode_t  lex_mode;
  logic [15:0] pos_line, pos_col, lex_line, lex_col;
  logic [7:0]  lex_len, word_mask;
  bit          lex_stopped;
  int          step_count;

  c_subset_lexer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Move the source position past one byte, saturating
  function automatic void bump_pos(input logic [7:0] c);
    if (c == CH_NL) begin
      if (pos_line != 16'hFFFF) pos_line++;
      pos_col = 16'd1;
    end else if (pos_col != 16'hFFFF) begin
      pos_col++;
    end
  endfunction

  function automatic void open_token();
    lex_line = pos_line;
    lex_col  = pos_col;
    lex_len  = 8'd0;
  endfunction

  function automatic void take_byte(input logic [7:0] c);
    if (lex_len != 8'hFF) lex_len++;
    bump_pos(c);
  endfunction

  function automatic void push_token(input logic [5:0] kind, input logic [7:0] len,
                                     input logic [2:0] err);
    token_t t;
    if (step_count < 2) begin
      t.kind = kind;
      t.line = lex_line;
      t.col  = lex_col;
      t.len  = len;
      t.err  = err;
      t.last = 1'b0;
      tokens_due.push_back(t);
      step_count++;
    end
  endfunction

  function automatic void stop_with(input logic [7:0] len, input logic [2:0] err);
    push_token(K_ERR, len, err);
    lex_stopped = 1'b1;
    lex_mode    = M_IDLE;
  endfunction

  // Drop keywords that no longer fit the identifier, then take the byte
  function automatic void word_byte(input logic [7:0] c);
    for (int k = 0; k < 8; k++) begin
      if (lex_len >= kw_words[k].len() || lex_len >= MAX_LEX || kw_words[k][lex_len] != c)
        word_mask[k] = 1'b0;
    end
    take_byte(c);
  endfunction

  function automatic logic [5:0] word_kind();
    for (int k = 0; k < 8; k++) begin
      if (word_mask[k] && kw_words[k].len() == lex_len) return K_KW0 + 6'(k);
    end
    return K_IDENT;
  endfunction

  function automatic void scan_from_idle(input logic [7:0] c);
    logic [5:0] k;
    scan_mode_t nxt;
    lex_mode = M_IDLE;
    k   = K_END;
    nxt = M_IDLE;
    if (c == CH_NUL) begin
      open_token();
      push_token(K_END, 8'd0, E_NONE);
    end else if (c == CH_SP || c == CH_NL || c == CH_TAB || c == CH_BLANK2) begin
      bump_pos(c);
    end else begin
      open_token();
      if (digit_ch(c)) begin
        take_byte(c);
        lex_mode = M_INT;
      end else if (letter_ch(c)) begin
        word_mask = 8'hFF;
        word_byte(c);
        lex_mode = M_IDENT;
      end else begin
        case (c)
          CH_PLUS:   k = K_PLUS;
          CH_MINUS:  k = K_MINUS;
          CH_STAR:   k = K_STAR;
          CH_PCT:    k = K_PCT;
          CH_COMMA:  k = K_COMMA;
          CH_SEMI:   k = K_SEMI;
          CH_LBRACE: k = K_LBRACE;
          CH_RBRACE: k = K_RBRACE;
          CH_LPAREN: k = K_LPAREN;
          CH_RPAREN: k = K_RPAREN;
          CH_SLASH:  nxt = M_SLASH;
          CH_QUOTE:  nxt = M_Q1;
          CH_LT:     nxt = M_LT;
          CH_GT:     nxt = M_GT;
          CH_EQ:     nxt = M_EQ;
          CH_BANG:   nxt = M_BANG;
          default:   ;
        endcase
        if (k != K_END) begin
          take_byte(c);
          push_token(k, lex_len, E_NONE);
        end else if (nxt != M_IDLE) begin
          take_byte(c);
          lex_mode = nxt;
        end else begin
          stop_with(8'd0, E_UNKNOWN);
        end
      end
    end
  endfunction

  // Second byte of a possible two-byte operator
  function automatic void second_of_pair(input logic [7:0] c, input logic [5:0] single,
                                         input logic [5:0] with_eq, input logic [7:0] dup,
                                         input logic [5:0] with_dup);
    if (c == CH_EQ) begin
      take_byte(c);
      push_token(with_eq, lex_len, E_NONE);
      lex_mode = M_IDLE;
    end else if (dup != CH_NUL && c == dup) begin
      take_byte(c);
      push_token(with_dup, lex_len, E_NONE);
      lex_mode = M_IDLE;
    end else begin
      push_token(single, lex_len, E_NONE);
      scan_from_idle(c);
    end
  endfunction

  // Predict the tokens one accepted byte releases and queue them
  function automatic void scan_byte(input logic [7:0] c);
    step_count = 0;
    if (!lex_stopped) begin
      case (lex_mode)
        M_COMMENT: begin
          if (c == CH_NL || c == CH_NUL) scan_from_idle(c);
          else bump_pos(c);
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            bump_pos(c);
            lex_mode = M_COMMENT;
          end else begin
            push_token(K_SLASH, lex_len, E_NONE);
            scan_from_idle(c);
          end
        end
        M_INT: begin
          if (digit_ch(c)) begin
            take_byte(c);
          end else begin
            push_token(K_INT, lex_len, E_NONE);
            scan_from_idle(c);
          end
        end
        M_IDENT: begin
          if (digit_ch(c) || letter_ch(c)) begin
            word_byte(c);
          end else begin
            push_token(word_kind(), lex_len, E_NONE);
            scan_from_idle(c);
          end
        end
        M_LT: second_of_pair(c, K_LT, K_LE, CH_LT, K_SHL);
        M_GT: second_of_pair(c, K_GT, K_GE, CH_GT, K_SHR);
        M_EQ: second_of_pair(c, K_ASSIGN, K_EQEQ, CH_NUL, K_END);
        M_BANG: begin
          if (c == CH_EQ) begin
            take_byte(c);
            push_token(K_NE, lex_len, E_NONE);
            lex_mode = M_IDLE;
          end else begin
            stop_with(lex_len, E_BANG);
          end
        end
        M_Q1: begin
          if (c == CH_QUOTE) begin
            take_byte(c);
            stop_with(lex_len, E_EMPTY);
          end else if (c == CH_BSLASH) begin
            take_byte(c);
            lex_mode = M_QESC;
          end else if (c == CH_NUL) begin
            stop_with(lex_len, E_LONG);
          end else begin
            take_byte(c);
            lex_mode = M_QBODY;
          end
        end
        M_QESC: begin
          if (c == CH_QUOTE) begin
            take_byte(c);
            stop_with(lex_len, E_ESCQ);
          end else if (c == CH_NUL) begin
            stop_with(lex_len, E_LONG);
          end else begin
            take_byte(c);
            lex_mode = M_QBODY;
          end
        end
        M_QBODY: begin
          if (c == CH_QUOTE) begin
            take_byte(c);
            push_token(K_CHAR, lex_len, E_NONE);
            lex_mode = M_IDLE;
          end else if (c == CH_NUL) begin
            stop_with(lex_len, E_LONG);
          end else begin
            take_byte(c);
            stop_with(lex_len, E_LONG);
          end
        end
        default: scan_from_idle(c);
      endcase
    end
    if (step_count > 0) tokens_due[$].last = 1'b1;
  endfunction

  task automatic flag(input string what, input int got, input int want);
    fails++;
    $display("tb: mismatch on %s, got %0d want %0d at %0t", what, got, want, $time);
  endtask

  function automatic int idle_pct(input bit rx_side);
    if (bytes_in < PHASE_A) return rx_side ? 52 : 6;
    if (bytes_in < PHASE_B) return rx_side ? 6 : 52;
    return 0;
  endfunction

  // Stimulus helpers
  task automatic push_byte(input logic [7:0] c);
    source_text.push_back('{c, drain_next});
    drain_next = 1'b0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char(input bit letters_only);
    int r;
    r = $urandom_range(letters_only ? 51 : 61);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    return 8'(8'h30 + r - 52);
  endfunction

  task automatic push_word(input int n);
    push_byte(word_char(1'b1));
    for (int i = 1; i < n; i++) push_byte(word_char(1'b0));
  endtask

  task automatic push_number(input int n);
    for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(9)));
  endtask

  // Append one well-formed lexeme or a bit of harmless noise
  task automatic gen_fragment();
    int pick, n;
    string w, noise;
    logic [7:0] c;
    noise = "aZ09+-*%,;{}()<>= \t\n";
    pick = $urandom_range(99);
    if (pick < 15) begin
      w = kw_words[$urandom_range(7)];
      case ($urandom_range(4))
        0: push_text(w.substr(0, w.len() - 2));
        1: begin
          push_text(w);
          push_byte(word_char(1'b0));
        end
        default: push_text(w);
      endcase
      if ($urandom_range(4) != 0) push_byte(CH_SP);
    end else if (pick < 30) begin
      n = ($urandom_range(29) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      push_word(n);
      if ($urandom_range(4) != 0) push_byte(CH_SP);
    end else if (pick < 40) begin
      push_number($urandom_range(1, 6));
      if ($urandom_range(2) != 0) push_byte(CH_SP);
    end else if (pick < 60) begin
      w = op_words[$urandom_range(19)];
      push_text(w);
      // keep a lone slash from opening a comment
      if (w == "/") push_byte(CH_SP);
    end else if (pick < 68) begin
      push_byte(CH_QUOTE);
      if ($urandom_range(1) == 0) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
      end else begin
        push_byte(CH_BSLASH);
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
      end
      push_byte(c);
      push_byte(CH_QUOTE);
    end else if (pick < 75) begin
      push_text("//");
      n = $urandom_range(10);
      for (int i = 0; i < n; i++) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
        push_byte(c);
      end
      push_byte(CH_NL);
    end else if (pick < 90) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(3))
          0: push_byte(CH_SP);
          1: push_byte(CH_TAB);
          2: push_byte(CH_NL);
          default: push_byte(CH_BLANK2);
        endcase
      end
    end else if (pick < 94) begin
      push_byte(CH_NUL);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) push_byte(CH_NUL);
        else push_byte(noise[$urandom_range(noise.len() - 1)]);
      end
    end
  endtask

  // Close the text with one error; everything after it must be dropped
  task automatic push_error_tail();
    string unknown;
    unknown = "\r\"#$&?@[]^_|~";
    push_byte(CH_SP);
    case ($urandom_range(8))
      0: push_text("''");
      1: push_text("'\\''");
      2: begin
        push_text("'a");
        push_byte(word_char(1'b1));
      end
      3: push_text("'\\nq");
      4: begin
        push_byte(CH_QUOTE);
        push_byte(CH_NUL);
      end
      5: begin
        push_text("'\\");
        push_byte(CH_NUL);
      end
      6: begin
        push_text("'a");
        push_byte(CH_NUL);
      end
      7: begin
        push_byte(CH_BANG);
        push_byte(word_char(1'b0));
      end
      default: push_byte(unknown[$urandom_range(unknown.len() - 1)]);
    endcase
    repeat (6) push_byte(8'($urandom_range(255)));
  endtask

  // Driver: offer queued bytes, predict each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        scan_byte(s_tdata);
        bytes_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (source_text.size() != 0 && !(source_text[0].drain && tokens_due.size() != 0) &&
            $urandom_range(99) >= idle_pct(1'b0)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= source_text[0].ch;
          void'(source_text.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each token beat with the oldest prediction
  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tokens_due.size() == 0) begin
          flag("token with nothing due, kind", m_tuser, -1);
        end else begin
          want = tokens_due.pop_front();
          if (m_tuser != want.kind) flag("token_kind", m_tuser, want.kind);
          if (m_tdata[15:0] != want.line) flag("start_line", m_tdata[15:0], want.line);
          if (m_tdata[31:16] != want.col) flag("start_column", m_tdata[31:16], want.col);
          if (m_tdata[39:32] != want.len) flag("token_length", m_tdata[39:32], want.len);
          if (m_tdata[42:40] != want.err) flag("error_code", m_tdata[42:40], want.err);
          if (m_tlast != want.last) flag("last", m_tlast, want.last);
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // Hold off the receiver long enough for the token queue to fill
  initial begin
    wait (bytes_in >= 150);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    bit drained;
    lex_mode    = M_IDLE;
    pos_line    = 16'd1;
    pos_col     = 16'd1;
    lex_line    = 16'd1;
    lex_col     = 16'd1;
    lex_len     = 8'd0;
    word_mask   = 8'hFF;
    lex_stopped = 1'b0;
    drain_next  = 1'b0;
    drained     = 1'b0;

    // Directed opening: keyword, int, char escape, pairs, blanks, comment, end
    push_text("int x=09;\t'\\q'<=a>>b!=c");
    push_byte(CH_BLANK2);
    push_text("//z\n");
    push_byte(CH_NUL);

    // Random text; pause the sender for a full drain twice
    drain_next = 1'b1;
    while (source_text.size() < MAIN_BYTES) begin
      if (!drained && source_text.size() >= 250) begin
        drain_next = 1'b1;
        drained    = 1'b1;
      end
      gen_fragment();
    end

    // Saturate token length on a long identifier and a long number
    push_byte(CH_SP);
    push_text("go ");
    push_word(260);
    push_byte(CH_SP);
    push_number(258);
    push_text(" x1\n+ ");
    push_error_tail();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (source_text.size() != 0 || s_tvalid) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
